>>> sv/gbre_pkg.sv
`default_nettype none
package gbre_pkg;
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RED_SUM  = 3'd0,
      RED_MEAN = 3'd1,
      RED_PROD = 3'd2,
      RED_MAX  = 3'd3,
      RED_MIN  = 3'd4,
      RED_ANY  = 3'd5,
      RED_ALL  = 3'd6,
      RED_RSV  = 3'd7
   } red_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_STORE = 2'd2,
      ST_RSV   = 2'd3
   } status_type;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SUB_W       = 11;
   localparam int RED_W       = 3;

   localparam int REG_REDUCER = 0;
   localparam int REG_FILL    = 1;
   localparam int REG_DIM1    = 2;
   localparam int REG_DIM2    = 3;
   localparam int REG_DIM3    = 4;
endpackage
`default_nettype wire

>>> sv/gbre_div.sv
`default_nettype none
module gbre_div #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [VALUE_WIDTH-1:0] dividend,
   input  wire logic        [COUNT_WIDTH-1:0] divisor,
   output logic                               done,
   output logic signed      [VALUE_WIDTH-1:0] quotient
);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic              busy_ff, busy_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;
   logic [COUNT_WIDTH:0]   r_ff, r_in;
   logic [COUNT_WIDTH-1:0] d_ff, d_in;
   logic              done_ff, done_in;
   logic [COUNT_WIDTH:0]   shifted;
   logic [VALUE_WIDTH-1:0] mag;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      done_in = 1'b0;
      mag     = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      shifted = {r_ff[COUNT_WIDTH-1:0], q_ff[VALUE_WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(VALUE_WIDTH);
         neg_in  = dividend[VALUE_WIDTH-1];
         q_in    = mag;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule
`default_nettype wire

>>> sv/group_by_reduce_engine_core.sv
// Each accumulate or read runs S_IDX1, S_IDX2, S_IDX3 and S_CHECK; an out-of-range one
// then goes to S_OUT, a read runs S_RDWAIT and S_OP, an accumulate also S_WRITE, a product
// accumulate S_MUL and S_WRITE, and a mean read of a touched cell S_DIVW and S_DIV (32-step
// divide). One item at a time: the next item is taken only once the result is registered
// and the state is back in S_IDLE. A clear answers via S_OUT, then clears every mark in S_SWEEP.
// Reset is synchronous; it runs the same sweep, so no item is taken until the sweep ends.
`default_nettype none
module group_by_reduce_engine_core #(
   parameter int CELLS       = 1024,
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [1:0]                              req_cmd,
   input  wire logic [10:0]                             req_sub_first,
   input  wire logic [10:0]                             req_sub_second,
   input  wire logic [10:0]                             req_sub_third,
   input  wire logic signed [gbre_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [gbre_pkg::VALUE_WIDTH-1:0]      rsp_result_value,
   output logic [1:0]                                   rsp_status,
   output logic                                         rsp_cell_touched,
   input  wire logic                                    psel,
   input  wire logic                                    penable,
   input  wire logic                                    pwrite,
   input  wire logic [4:0]                              paddr,
   input  wire logic [31:0]                             pwdata,
   output logic [31:0]                                  prdata,
   output logic                                         pready
);
   import gbre_pkg::*;

   localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int LW  = 33;
   localparam int PW  = 2 * VALUE_WIDTH;
   localparam int SW  = 2 * SUB_W;
   localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] QONE = VALUE_WIDTH'(1) << FRAC_BITS;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_IDX1, S_IDX2, S_IDX3, S_CHECK, S_RDWAIT, S_OP, S_MUL,
      S_WRITE, S_DIV, S_DIVW, S_OUT
   } state_type;

   // Configuration registers.
   logic [RED_W-1:0]             reducer_ff;
   logic signed [VALUE_WIDTH-1:0] fill_ff;
   logic [SUB_W-1:0]             dim1_ff, dim2_ff, dim3_ff;
   logic                         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         reducer_ff <= '0;
         fill_ff    <= '0;
         dim1_ff    <= SUB_W'(1024);
         dim2_ff    <= SUB_W'(1);
         dim3_ff    <= SUB_W'(1);
      end else if (wr_en) begin
         case (paddr[4:2])
            3'(REG_REDUCER): reducer_ff <= pwdata[RED_W-1:0];
            3'(REG_FILL):    fill_ff    <= VALUE_WIDTH'(signed'(pwdata));
            3'(REG_DIM1):    dim1_ff    <= pwdata[SUB_W-1:0];
            3'(REG_DIM2):    dim2_ff    <= pwdata[SUB_W-1:0];
            3'(REG_DIM3):    dim3_ff    <= pwdata[SUB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         3'(REG_REDUCER): prdata = 32'(reducer_ff);
         3'(REG_FILL):    prdata = 32'(fill_ff);
         3'(REG_DIM1):    prdata = 32'(dim1_ff);
         3'(REG_DIM2):    prdata = 32'(dim2_ff);
         3'(REG_DIM3):    prdata = 32'(dim3_ff);
         default:         prdata = '0;
      endcase
   end

   // Memories.
   logic signed [VALUE_WIDTH-1:0] val_mem [CELLS];
   logic [COUNT_WIDTH-1:0]        cnt_mem [CELLS];
   logic                          mark_mem [CELLS];
   logic signed [VALUE_WIDTH-1:0] val_rd_ff;
   logic [COUNT_WIDTH-1:0]        cnt_rd_ff;
   logic                          mark_rd_ff;

   // Sequencer state.
   state_type                     state_ff;
   logic [AW-1:0]                 sweep_ff;
   cmd_type                       cmd_ff;
   logic [SUB_W-1:0]              s1_ff, s2_ff, s3_ff;
   logic signed [VALUE_WIDTH-1:0] v_ff;
   logic [LW-1:0]                 lin_ff;
   logic [SW-1:0]                 stride_ff;
   logic [PW-1:0]                 prod_ff;
   logic                          pneg_ff;
   logic signed [VALUE_WIDTH-1:0] newv_ff;
   logic [COUNT_WIDTH-1:0]        newc_ff;
   logic signed [VALUE_WIDTH-1:0] res_val_ff;
   logic [1:0]                    res_st_ff;
   logic                          res_t_ff;
   logic                          out_valid_ff;
   logic signed [VALUE_WIDTH-1:0] out_val_ff;
   logic [1:0]                    out_st_ff;
   logic                          out_t_ff;
   logic                          div_start_ff;

   // Shared multiplier.
   logic [VALUE_WIDTH-1:0] mul_a, mul_b;
   logic [PW-1:0]          mul_p;
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   logic [SUB_W-1:0]       sm1, sm2, sm3;
   logic                   bad1, bad2, bad3;
   assign sm1  = s1_ff - 1'b1;
   assign sm2  = s2_ff - 1'b1;
   assign sm3  = s3_ff - 1'b1;
   assign bad1 = (s1_ff == '0) || (s1_ff > dim1_ff);
   assign bad2 = (s2_ff == '0) || (s2_ff > dim2_ff);
   assign bad3 = (s3_ff == '0) || (s3_ff > dim3_ff);

   logic [VALUE_WIDTH-1:0] mag_acc, mag_v;
   logic signed [VALUE_WIDTH-1:0] acc_eff;
   logic signed [VALUE_WIDTH:0]   sum_w;
   logic signed [VALUE_WIDTH-1:0] sum_sat;
   logic [PW-1:0]          prnd;
   logic signed [VALUE_WIDTH-1:0] prod_sat;
   logic [AW-1:0]          addr;

   assign addr = lin_ff[AW-1:0];

   always_comb begin
      acc_eff = mark_rd_ff ? val_rd_ff : QONE;
      mag_acc = acc_eff[VALUE_WIDTH-1] ? (~acc_eff + 1'b1) : acc_eff;
      mag_v   = v_ff[VALUE_WIDTH-1] ? (~v_ff + 1'b1) : v_ff;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_IDX1:  begin mul_a = VALUE_WIDTH'(sm2); mul_b = VALUE_WIDTH'(dim1_ff); end
         S_IDX2:  begin mul_a = VALUE_WIDTH'(dim1_ff); mul_b = VALUE_WIDTH'(dim2_ff); end
         S_IDX3:  begin mul_a = VALUE_WIDTH'(sm3); mul_b = VALUE_WIDTH'(stride_ff); end
         S_OP:    begin mul_a = mag_acc; mul_b = mag_v; end
         default: ;
      endcase
      sum_w   = {val_rd_ff[VALUE_WIDTH-1], val_rd_ff} + {v_ff[VALUE_WIDTH-1], v_ff};
      if (sum_w > signed'({VMAX[VALUE_WIDTH-1], VMAX}))      sum_sat = VMAX;
      else if (sum_w < signed'({VMIN[VALUE_WIDTH-1], VMIN})) sum_sat = VMIN;
      else                                                   sum_sat = sum_w[VALUE_WIDTH-1:0];
      prnd = (prod_ff + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (pneg_ff) begin
         if (prnd > PW'(VMAX) + PW'(1)) prod_sat = VMIN;
         else                           prod_sat = VALUE_WIDTH'(~prnd + 1'b1);
      end else begin
         if (prnd > PW'(VMAX)) prod_sat = VMAX;
         else                  prod_sat = VALUE_WIDTH'(prnd);
      end
   end

   logic                          div_done;
   logic signed [VALUE_WIDTH-1:0] div_q;

   gbre_div #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (val_rd_ff),
      .divisor  (cnt_rd_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   logic req_take, rsp_take, emit, div_go;
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign emit     = (state_ff == S_OUT) && (!out_valid_ff || rsp_take);
   assign div_go   = (state_ff == S_OP) && (cmd_ff == CMD_READ) && mark_rd_ff &&
                     (red_type'(reducer_ff) == RED_MEAN) && (cnt_rd_ff != '0);

   // Memory ports.
   always_ff @(posedge clock) begin
      val_rd_ff  <= val_mem[addr];
      cnt_rd_ff  <= cnt_mem[addr];
      mark_rd_ff <= mark_mem[addr];
      if (state_ff == S_SWEEP) begin
         mark_mem[sweep_ff] <= 1'b0;
      end else if (state_ff == S_WRITE) begin
         val_mem[addr]  <= newv_ff;
         cnt_mem[addr]  <= newc_ff;
         mark_mem[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= div_go;
         if (emit) begin
            out_valid_ff <= 1'b1;
            out_val_ff   <= res_val_ff;
            out_st_ff    <= res_st_ff;
            out_t_ff     <= res_t_ff;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_SWEEP: begin
               if (sweep_ff == AW'(CELLS - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_take) begin
                  cmd_ff <= cmd_type'(req_cmd);
                  s1_ff  <= req_sub_first;
                  s2_ff  <= req_sub_second;
                  s3_ff  <= req_sub_third;
                  v_ff   <= req_value;
                  lin_ff <= '0;
                  case (cmd_type'(req_cmd))
                     CMD_ACCUM, CMD_READ: state_ff <= S_IDX1;
                     default: begin
                        res_val_ff <= '0;
                        res_st_ff  <= ST_OK;
                        res_t_ff   <= 1'b0;
                        state_ff   <= S_OUT;
                     end
                  endcase
               end
            end
            S_IDX1: begin
               lin_ff   <= LW'(sm1) + LW'(mul_p);
               state_ff <= S_IDX2;
            end
            S_IDX2: begin
               stride_ff <= mul_p[SW-1:0];
               state_ff  <= S_IDX3;
            end
            S_IDX3: begin
               lin_ff   <= lin_ff + LW'(mul_p);
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (bad1 || bad2 || bad3 || lin_ff >= LW'(CELLS)) begin
                  res_val_ff <= '0;
                  res_st_ff  <= (bad1 || bad2 || bad3) ? ST_RANGE : ST_STORE;
                  res_t_ff   <= 1'b0;
                  state_ff   <= S_OUT;
               end else begin
                  state_ff <= S_RDWAIT;
               end
            end
            S_RDWAIT: state_ff <= S_OP;
            S_OP: begin
               prod_ff <= mul_p;
               pneg_ff <= acc_eff[VALUE_WIDTH-1] != v_ff[VALUE_WIDTH-1];
               if (cmd_ff == CMD_READ) begin
                  res_st_ff <= ST_OK;
                  res_t_ff  <= mark_rd_ff;
                  if (!mark_rd_ff) begin
                     res_val_ff <= fill_ff;
                     state_ff   <= S_OUT;
                  end else if (div_go) begin
                     state_ff <= S_DIVW;
                  end else begin
                     res_val_ff <= val_rd_ff;
                     state_ff   <= S_OUT;
                  end
               end else begin
                  newc_ff <= !mark_rd_ff ? COUNT_WIDTH'(1) :
                             (cnt_rd_ff == CMAX ? cnt_rd_ff : cnt_rd_ff + 1'b1);
                  case (red_type'(reducer_ff))
                     RED_PROD: newv_ff <= '0;
                     RED_MAX:  newv_ff <= (!mark_rd_ff || v_ff > val_rd_ff) ? v_ff : val_rd_ff;
                     RED_MIN:  newv_ff <= (!mark_rd_ff || v_ff < val_rd_ff) ? v_ff : val_rd_ff;
                     RED_ANY:  newv_ff <= ((mark_rd_ff && val_rd_ff != '0) || v_ff != '0)
                                          ? QONE : '0;
                     RED_ALL:  newv_ff <= ((!mark_rd_ff || val_rd_ff != '0) && v_ff != '0)
                                          ? QONE : '0;
                     default:  newv_ff <= mark_rd_ff ? sum_sat : v_ff;
                  endcase
                  state_ff <= (red_type'(reducer_ff) == RED_PROD) ? S_MUL : S_WRITE;
               end
            end
            S_MUL: begin
               newv_ff  <= prod_sat;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               res_val_ff <= '0;
               res_st_ff  <= ST_OK;
               res_t_ff   <= 1'b1;
               state_ff   <= S_OUT;
            end
            S_DIVW: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  res_val_ff <= div_q;
                  state_ff   <= S_OUT;
               end
            end
            S_OUT: begin
               if (emit) state_ff <= (cmd_ff == CMD_CLEAR) ? S_SWEEP : S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_val_ff;
   assign rsp_status       = out_st_ff;
   assign rsp_cell_touched = out_t_ff;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_take)
      else $error("item accepted while busy");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value)))
      else $error("stalled result changed");
   a_bad_status_untouched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> !rsp_cell_touched)
      else $error("error result flagged touched");
   a_div_only_mean: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> (state_ff == S_DIVW))
      else $error("divider started outside mean read");
endmodule
`default_nettype wire
